>>> sv/jlcs_pkg.sv
// ----------------------------------------------------------------------------
// jlcs_pkg
// Types and constants shared by the jerk-limited corner speed block.
// ----------------------------------------------------------------------------
`default_nettype none

package jlcs_pkg;

  localparam int AXES     = 4;
  localparam int AXIS_W   = $clog2(AXES);
  localparam int STEP_W   = 24;
  localparam int FEED_W   = 20;
  localparam int JERK_W   = 16;
  localparam int DIR_W    = AXES;
  // Speed quotients can be as wide as steps times feedrate.
  localparam int PROD_W   = STEP_W + FEED_W;
  localparam int CNT_W    = $clog2(PROD_W + 1);
  localparam int FACT_W   = 10;

  localparam logic [FACT_W-1:0] FACTOR_START = FACT_W'(2 << 8);
  localparam logic [FACT_W-1:0] FACTOR_ONE   = FACT_W'(1 << 8);
  localparam logic [JERK_W-1:0] JERK_RESET   = JERK_W'(200);
  localparam logic [CNT_W-1:0]  SPEED_BITS   = CNT_W'(PROD_W);
  localparam logic [CNT_W-1:0]  JERK_BITS    = CNT_W'(JERK_W + 8);
  localparam logic [AXIS_W-1:0] AXIS_LAST    = AXIS_W'(AXES - 1);

  typedef struct packed {
    logic              chain_start;
    logic [STEP_W-1:0] steps_x;
    logic [STEP_W-1:0] steps_y;
    logic [STEP_W-1:0] steps_z;
    logic [STEP_W-1:0] steps_e;
    logic [DIR_W-1:0]  directions;
    logic [STEP_W-1:0] major_steps;
    logic [FEED_W-1:0] feedrate;
  } in_t;

  typedef struct packed {
    logic [FEED_W-1:0] cross_speed;
    logic              joined;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_SPD,
    ST_DV,
    ST_JMIN,
    ST_SCALE,
    ST_FIN
  } state_t;

endpackage

`default_nettype wire

>>> sv/jerk_limited_corner_speed.sv
// ----------------------------------------------------------------------------
// jerk_limited_corner_speed
// Corner speed between consecutive planned moves, limited by per-axis jerk.
// ----------------------------------------------------------------------------
// One item is one planned move; one result item comes out for every move.
// Multiplication and division run through a single multiplier and a single
// restoring divider that produces one quotient bit per cycle. A joined move
// keeps the block busy after it is accepted: per axis each of the two speed
// divisions runs a multiply step, 44 quotient bits and a store step, then the
// speed change is formed and the 24-bit jerk division and the minimum run;
// then come a scaling step and a step to load the result. A zero step total
// skips the quotient bits of that speed, and an axis whose speed change is
// zero skips its jerk division. A move with no previous move to join with goes
// straight to loading the result. The block takes a new item while the last
// result still waits in the output register, and holds a finished result while
// that register stays full.
`default_nettype none

module jerk_limited_corner_speed
  import jlcs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [AXIS_W-1:0] cfg_addr,
  input  wire logic [JERK_W-1:0] cfg_data,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire in_t               in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output out_t                   out_data
);

  state_t state, state_next;

  logic [JERK_W-1:0] jerk [AXES];

  logic              prev_valid;
  logic [STEP_W-1:0] prev_steps [AXES];
  logic [DIR_W-1:0]  prev_dirs;
  logic [STEP_W-1:0] prev_total;
  logic [FEED_W-1:0] prev_feed;

  in_t               cur;
  logic [STEP_W-1:0] cur_steps [AXES];

  logic [FEED_W-1:0] f;
  logic [FACT_W-1:0] factor;
  logic [AXIS_W-1:0] axis;
  logic              phase;
  logic              div_jerk;
  logic [PROD_W-1:0] vp;
  logic [PROD_W:0]   dv;
  logic [FEED_W-1:0] corner_spd;
  logic              joined;

  // Shared divider: dq holds the dividend and collects quotient bits.
  logic [PROD_W-1:0] dq;
  logic [PROD_W:0]   drem;
  logic [PROD_W:0]   dden;
  logic [CNT_W-1:0]  cnt;

  logic              accept;
  logic              join_now;
  logic              out_free;
  logic [STEP_W-1:0] mul_a;
  logic [PROD_W-1:0] mul_p;
  logic [STEP_W-1:0] sel_total;
  logic [PROD_W+1:0] rem_sh;
  logic [PROD_W+1:0] rem_sub;
  logic              rem_ge;
  logic [PROD_W-1:0] dq_step;
  logic [PROD_W:0]   drem_step;
  logic [PROD_W-1:0] absdiff;
  logic              same_dir;

  assign cur_steps[0] = cur.steps_x;
  assign cur_steps[1] = cur.steps_y;
  assign cur_steps[2] = cur.steps_z;
  assign cur_steps[3] = cur.steps_e;

  assign accept   = in_valid && in_ready;
  assign join_now = !in_data.chain_start && prev_valid;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    if (state == ST_SCALE) begin
      mul_a = STEP_W'(factor);
    end else if (phase) begin
      mul_a = cur_steps[axis];
    end else begin
      mul_a = prev_steps[axis];
    end
    mul_p     = PROD_W'(mul_a) * PROD_W'(f);
    sel_total = phase ? cur.major_steps : prev_total;
  end

  always_comb begin
    rem_sh    = {drem, dq[PROD_W-1]};
    rem_sub   = rem_sh - {1'b0, dden};
    rem_ge    = rem_sh >= {1'b0, dden};
    drem_step = rem_ge ? rem_sub[PROD_W:0] : rem_sh[PROD_W:0];
    dq_step   = {dq[PROD_W-2:0], rem_ge};
  end

  // dq holds the current axis speed when this is used.
  always_comb begin
    same_dir = prev_dirs[axis] == cur.directions[axis];
    absdiff  = (dq > vp) ? (dq - vp) : (vp - dq);
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = join_now ? ST_MUL : ST_FIN;
        end
      end
      ST_MUL: begin
        state_next = (sel_total == '0) ? ST_SPD : ST_DIV;
      end
      ST_DIV: begin
        if (cnt == CNT_W'(1)) begin
          state_next = div_jerk ? ST_JMIN : ST_SPD;
        end
      end
      ST_SPD: begin
        state_next = phase ? ST_DV : ST_MUL;
      end
      ST_DV: begin
        if (dv != '0) begin
          state_next = ST_DIV;
        end else begin
          state_next = (axis == AXIS_LAST) ? ST_SCALE : ST_MUL;
        end
      end
      ST_JMIN: begin
        state_next = (axis == AXIS_LAST) ? ST_SCALE : ST_MUL;
      end
      ST_SCALE: begin
        state_next = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_ready = state == ST_IDLE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < AXES; i++) begin
        jerk[i] <= JERK_RESET;
      end
    end else if (cfg_we) begin
      jerk[cfg_addr] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      prev_valid <= 1'b0;
    end else if (state == ST_FIN && out_free) begin
      out_valid  <= 1'b1;
      prev_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          cur        <= in_data;
          f          <= (prev_feed < in_data.feedrate) ? prev_feed : in_data.feedrate;
          factor     <= FACTOR_START;
          axis       <= '0;
          phase      <= 1'b0;
          corner_spd <= '0;
          joined     <= join_now;
        end
      end
      ST_MUL: begin
        // A zero total gives zero speed; a zero product divides to zero anyway.
        dq       <= (sel_total == '0) ? '0 : mul_p;
        drem     <= '0;
        dden     <= (PROD_W+1)'(sel_total);
        cnt      <= SPEED_BITS;
        div_jerk <= 1'b0;
      end
      ST_DIV: begin
        dq   <= dq_step;
        drem <= drem_step;
        cnt  <= cnt - CNT_W'(1);
      end
      ST_SPD: begin
        if (!phase) begin
          vp    <= dq;
          phase <= 1'b1;
        end else begin
          dv <= same_dir ? {1'b0, absdiff} : ({1'b0, vp} + {1'b0, dq});
        end
      end
      ST_DV: begin
        if (dv != '0) begin
          // The jerk dividend sits at the top so only its bits are iterated.
          dq       <= {jerk[axis], 8'd0, {(PROD_W-JERK_W-8){1'b0}}};
          drem     <= '0;
          dden     <= dv;
          cnt      <= JERK_BITS;
          div_jerk <= 1'b1;
        end else begin
          axis  <= axis + AXIS_W'(1);
          phase <= 1'b0;
        end
      end
      ST_JMIN: begin
        if (dq < PROD_W'(factor)) begin
          factor <= dq[FACT_W-1:0];
        end
        axis  <= axis + AXIS_W'(1);
        phase <= 1'b0;
      end
      ST_SCALE: begin
        corner_spd <= (factor >= FACTOR_ONE) ? f : mul_p[FEED_W+7:8];
      end
      ST_FIN: begin
        if (out_free) begin
          out_data.cross_speed <= corner_spd;
          out_data.joined      <= joined;
          for (int i = 0; i < AXES; i++) begin
            prev_steps[i] <= cur_steps[i];
          end
          prev_dirs  <= cur.directions;
          prev_total <= cur.major_steps;
          prev_feed  <= cur.feedrate;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire
